/* design/lobm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared constants and types for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int AMT_W     = 30;
    localparam int TOTAL_W   = 47;
    localparam int MOD_W     = 30;
    localparam int COUNT_W   = 7;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 96;

    localparam logic [MOD_W-1:0] BACKLOG_MODULUS = 30'd1000000007;
    // Restoring reduction: subtract modulus << k for k = MOD_STEPS-1 .. 0
    localparam int MOD_STEPS = TOTAL_W - MOD_W + 1;
    localparam int STEP_W    = $clog2(MOD_STEPS + 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SCAN    = 8'b0000_0010,
        ST_CHECK   = 8'b0000_0100,
        ST_MOVE_RD = 8'b0000_1000,
        ST_MOVE_WR = 8'b0001_0000,
        ST_PLACE   = 8'b0010_0000,
        ST_MOD     = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

endpackage
`default_nettype wire

/* design/limit_order_book_matcher_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Limit order matching engine with two bounded books and backlog reporting.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one limit order per transaction: s_tdata holds price
//   and amount, s_tuser holds the side (0 buy, 1 sell). m_ channel returns
//   one result per order: backlog total, total modulo 1e9+7, both entry
//   counts in m_tdata and the overflow-drop flag in m_tuser.
//   Each book lives in a RAM of BOOK_DEPTH entries. A single compare unit
//   scans the opposite book one entry per cycle to find the best price. A
//   fully consumed level passes through scan, check, move read and move
//   write. The rest is then placed, and the modulo reduction runs on one
//   shared 47-bit compare/subtract. An order with an empty opposite book or
//   a zero amount goes from scan straight to placing; each consumed level
//   adds a scan, check and move, and a final scan ends on a price that does
//   not cross or on a partial fill. One order is in flight at a time:
//   s_tready is high only when the sequencer is idle.
//   The result sits in an output register; a stalled receiver holds it and
//   the next order may still be accepted and processed, finishing only once
//   the register is free. Reset clears both counts and the total at once;
//   no clearing pass is needed since only entries below a count are read.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core #(
    parameter int BOOK_DEPTH = 64,
    parameter int PRICE_BITS = 30
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [29:0] price, [59:30] amount, [63:60] zero
    input  wire logic [lobm_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] side
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [46:0] backlog_total, [76:47] backlog_mod, [83:77] buy_entries,
    // [90:84] sell_entries, [95:91] zero
    output logic      [lobm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] overflow_drop
    output logic                                   m_tuser
);
    import lobm_pkg::*;

    localparam int AW    = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW    = $clog2(BOOK_DEPTH + 1);
    localparam int EW    = PRICE_BITS + AMT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

    state_t state_reg, state_next;

    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [AMT_W-1:0]      rest_reg, rest_next;
    logic                  side_reg, side_next;
    logic [CW-1:0]         bid_cnt_reg, bid_cnt_next;
    logic [CW-1:0]         ask_cnt_reg, ask_cnt_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  drop_reg, drop_next;

    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         prev_reg, prev_next;
    logic                  pv_reg, pv_next;
    logic [CW-1:0]         best_idx_reg, best_idx_next;
    logic [PRICE_BITS-1:0] best_p_reg, best_p_next;
    logic [AMT_W-1:0]      best_a_reg, best_a_next;

    logic [TOTAL_W-1:0]    rem_reg, rem_next;
    logic [TOTAL_W-1:0]    dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  m_user_reg, m_user_next;

    // RAM ports
    logic          opp_we, own_we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] bid_rdata, ask_rdata, opp_rdata;
    logic          bid_we, ask_we;

    logic [CW-1:0]         opp_cnt, own_cnt;
    logic [PRICE_BITS-1:0] rd_p;
    logic [AMT_W-1:0]      rd_a;
    logic                  better, crosses;

    lobm_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_bid_ram (
        .aclk  (aclk),
        .we    (bid_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (bid_rdata)
    );

    lobm_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_ask_ram (
        .aclk  (aclk),
        .we    (ask_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ask_rdata)
    );

    // Buy orders match against asks, sell orders against bids
    assign opp_rdata = side_reg ? bid_rdata : ask_rdata;
    assign opp_cnt   = side_reg ? bid_cnt_reg : ask_cnt_reg;
    assign own_cnt   = side_reg ? ask_cnt_reg : bid_cnt_reg;
    assign rd_p      = opp_rdata[EW-1:AMT_W];
    assign rd_a      = opp_rdata[AMT_W-1:0];
    assign better    = side_reg ? (rd_p > best_p_reg) : (rd_p < best_p_reg);
    assign crosses   = side_reg ? (best_p_reg >= price_reg) : (best_p_reg <= price_reg);
    assign bid_we    = (opp_we && side_reg) || (own_we && !side_reg);
    assign ask_we    = (opp_we && !side_reg) || (own_we && side_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        state_next    = state_reg;
        price_next    = price_reg;
        rest_next     = rest_reg;
        side_next     = side_reg;
        bid_cnt_next  = bid_cnt_reg;
        ask_cnt_next  = ask_cnt_reg;
        total_next    = total_reg;
        drop_next     = drop_reg;
        idx_next      = idx_reg;
        prev_next     = prev_reg;
        pv_next       = pv_reg;
        best_idx_next = best_idx_reg;
        best_p_next   = best_p_reg;
        best_a_next   = best_a_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        opp_we        = 1'b0;
        own_we        = 1'b0;
        waddr         = best_idx_reg[AW-1:0];
        wdata         = {best_p_reg, best_a_reg};
        raddr         = idx_reg[AW-1:0];

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    price_next = PRICE_BITS'(s_tdata[29:0]);
                    rest_next  = s_tdata[59:30];
                    side_next  = s_tuser;
                    drop_next  = 1'b0;
                    idx_next   = '0;
                    pv_next    = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!pv_reg && idx_reg == '0 && (rest_reg == '0 || opp_cnt == '0)) begin
                    state_next = ST_PLACE;
                end else begin
                    if (pv_reg && (prev_reg == '0 || better)) begin
                        best_idx_next = prev_reg;
                        best_p_next   = rd_p;
                        best_a_next   = rd_a;
                    end
                    if (idx_reg != opp_cnt) begin
                        idx_next  = idx_reg + 1'b1;
                        prev_next = idx_reg;
                        pv_next   = 1'b1;
                    end else begin
                        pv_next    = 1'b0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (!crosses) begin
                    state_next = ST_PLACE;
                end else if (best_a_reg > rest_reg) begin
                    // Partial fill: keep the remainder in place
                    opp_we     = 1'b1;
                    wdata      = {best_p_reg, best_a_reg - rest_reg};
                    total_next = total_reg - TOTAL_W'(rest_reg);
                    rest_next  = '0;
                    state_next = ST_PLACE;
                end else begin
                    rest_next  = rest_reg - best_a_reg;
                    total_next = total_reg - TOTAL_W'(best_a_reg);
                    if (side_reg) begin
                        bid_cnt_next = bid_cnt_reg - 1'b1;
                    end else begin
                        ask_cnt_next = ask_cnt_reg - 1'b1;
                    end
                    state_next = ST_MOVE_RD;
                end
            end
            ST_MOVE_RD: begin
                // Fetch the last entry to fill the hole
                raddr      = opp_cnt[AW-1:0];
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                opp_we     = 1'b1;
                wdata      = opp_rdata;
                idx_next   = '0;
                pv_next    = 1'b0;
                state_next = ST_SCAN;
            end
            ST_PLACE: begin
                waddr = own_cnt[AW-1:0];
                wdata = {price_reg, rest_reg};
                if (rest_reg != '0) begin
                    if (own_cnt >= DEPTH_C) begin
                        drop_next = 1'b1;
                    end else begin
                        own_we     = 1'b1;
                        total_next = total_reg + TOTAL_W'(rest_reg);
                        if (side_reg) begin
                            ask_cnt_next = ask_cnt_reg + 1'b1;
                        end else begin
                            bid_cnt_next = bid_cnt_reg + 1'b1;
                        end
                    end
                end
                rem_next   = total_next;
                dvs_next   = TOTAL_W'(BACKLOG_MODULUS) << (MOD_STEPS - 1);
                step_next  = '0;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                if (rem_reg >= dvs_reg) begin
                    rem_next = rem_reg - dvs_reg;
                end
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MOD_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, COUNT_W'(ask_cnt_reg), COUNT_W'(bid_cnt_reg),
                                    rem_reg[MOD_W-1:0], total_reg};
                    m_user_next  = drop_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bid_cnt_reg <= '0;
            ask_cnt_reg <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bid_cnt_reg <= bid_cnt_next;
            ask_cnt_reg <= ask_cnt_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            pv_reg      <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg    <= price_next;
        rest_reg     <= rest_next;
        side_reg     <= side_next;
        drop_reg     <= drop_next;
        idx_reg      <= idx_next;
        prev_reg     <= prev_next;
        best_idx_reg <= best_idx_next;
        best_p_reg   <= best_p_next;
        best_a_reg   <= best_a_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        step_reg     <= step_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

endmodule
`default_nettype wire

/* design/lobm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
